// File: rtl/sfr_pkg.sv
// sfr_pkg: shared types and constants of the stream find and replace block
`timescale 1ns / 1ps
package sfr_pkg;

  // field and counter widths
  localparam int BYTE_W     = 8;
  localparam int CNT_W      = 4;   // window counts, 0..8
  localparam int HCNT_W     = 3;   // held byte count, 0..7
  localparam int TOT_W      = 5;   // results of one transaction, 0..16
  localparam int LEN_W      = 4;   // length registers
  localparam int LIMIT_W    = 32;  // replacement limit and counter
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEARCH_PATTERN = 3'd0,
    REG_SEARCH_LENGTH  = 3'd1,
    REG_REPLACE_TEXT   = 3'd2,
    REG_REPLACE_LENGTH = 3'd3,
    REG_REPLACE_LIMIT  = 3'd4
  } cfg_reg_t;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] SEARCH_PATTERN_RST = '0;
  localparam logic [LEN_W-1:0]      SEARCH_LENGTH_RST  = 4'd1;
  localparam logic [CFG_DATA_W-1:0] REPLACE_TEXT_RST   = '0;
  localparam logic [LEN_W-1:0]      REPLACE_LENGTH_RST = 4'd0;
  localparam logic [LIMIT_W-1:0]    REPLACE_LIMIT_RST  = 32'hFFFF_FFFF;

  // queue occupancy codes
  localparam logic [1:0] QUEUE_EMPTY = 2'd0;
  localparam logic [1:0] QUEUE_FULL  = 2'd2;

  // what the front hands to the back for one input transaction
  typedef struct packed {
    logic [CNT_W-1:0] n_bytes;  // window bytes emitted first
    logic             rep;      // replacement text follows them
    logic             str_end;  // transaction closes the string
  } job_ctrl_t;

endpackage

// File: rtl/sfr_in_if.sv
// sfr_in_if: input byte channel with valid/ready handshake
`timescale 1ns / 1ps
interface sfr_in_if;
  import sfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              string_end;

  modport source (output valid, output data_byte, output string_end, input ready);
  modport sink   (input valid, input data_byte, input string_end, output ready);
endinterface

// File: rtl/sfr_out_if.sv
// sfr_out_if: result byte channel with valid/ready handshake
`timescale 1ns / 1ps
interface sfr_out_if;
  import sfr_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              byte_valid;
  logic              string_last;
  logic              run_last;

  modport source (output valid, output out_byte, output byte_valid, output string_last,
                  output run_last, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_last,
                  input run_last, output ready);
endinterface

// File: rtl/stream_find_replace_top.sv
// stream_find_replace_top: configuration registers and the front, queue and back
`timescale 1ns / 1ps
// Streaming find and replace. Bytes enter on in_ch; runs that could still begin a
// match of the search pattern are held back, and completed matches are swapped for
// the replacement text until replace_limit replacements were made in the string.
// Each input transaction yields from zero to sixteen output transactions; the last
// one of the string carries string_last, and a string with no output gives a bare
// end marker. The front accepts one byte per cycle while the two-entry job queue
// has room. The back emits one result per cycle while out_ch is not stalled; the
// output sequencer sets the rate. A result passes through the job queue and then
// the output register before it is offered.
// The user must write registers through cfg_we/cfg_index/cfg_wdata only while idle; the block does not enforce it.
module stream_find_replace_top #(
  parameter int PATTERN_BYTES = 8,
  parameter int REPLACE_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  sfr_in_if.sink                         in_ch,
  sfr_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import sfr_pkg::*;

  localparam int JOB_W = PATTERN_BYTES*BYTE_W + $bits(job_ctrl_t);

  logic [CFG_DATA_W-1:0] search_pattern_r;
  logic [LEN_W-1:0]      search_length_r;
  logic [CFG_DATA_W-1:0] replace_text_r;
  logic [LEN_W-1:0]      replace_length_r;
  logic [LIMIT_W-1:0]    replace_limit_r;

  logic                            push, pop, q_full, q_empty;
  logic [PATTERN_BYTES*BYTE_W-1:0] job_bytes, head_bytes;
  job_ctrl_t                       job_ctrl, head_ctrl;
  logic [JOB_W-1:0]                head_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_pattern_r <= SEARCH_PATTERN_RST;
      search_length_r  <= SEARCH_LENGTH_RST;
      replace_text_r   <= REPLACE_TEXT_RST;
      replace_length_r <= REPLACE_LENGTH_RST;
      replace_limit_r  <= REPLACE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SEARCH_PATTERN: search_pattern_r <= cfg_wdata;
        REG_SEARCH_LENGTH:  search_length_r  <= cfg_wdata[LEN_W-1:0];
        REG_REPLACE_TEXT:   replace_text_r   <= cfg_wdata;
        REG_REPLACE_LENGTH: replace_length_r <= cfg_wdata[LEN_W-1:0];
        REG_REPLACE_LIMIT:  replace_limit_r  <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // match and classify
  sfr_front #(.PATTERN_BYTES(PATTERN_BYTES)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .search_pattern (search_pattern_r),
    .search_length  (search_length_r),
    .replace_limit  (replace_limit_r),
    .queue_full     (q_full),
    .push           (push),
    .job_bytes      (job_bytes),
    .job_ctrl       (job_ctrl)
  );

  // job queue
  sfr_fifo #(.WIDTH(JOB_W)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data ({job_bytes, job_ctrl}),
    .pop       (pop),
    .head_data (head_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  assign head_bytes = head_data[JOB_W-1 -: PATTERN_BYTES*BYTE_W];
  assign head_ctrl  = job_ctrl_t'(head_data[$bits(job_ctrl_t)-1:0]);

  // result sequencer
  sfr_back #(
    .PATTERN_BYTES (PATTERN_BYTES),
    .REPLACE_BYTES (REPLACE_BYTES)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (q_empty),
    .head_bytes     (head_bytes),
    .head_ctrl      (head_ctrl),
    .pop            (pop),
    .replace_text   (replace_text_r),
    .replace_length (replace_length_r),
    .out_ch         (out_ch)
  );

endmodule

// File: rtl/sfr_front.sv
// sfr_front: matches each input byte against the pattern and issues emit jobs
`timescale 1ns / 1ps
module sfr_front #(
  parameter int PATTERN_BYTES = 8
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  sfr_in_if.sink                                 in_ch,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]         search_pattern,
  input  logic [sfr_pkg::LEN_W-1:0]              search_length,
  input  logic [sfr_pkg::LIMIT_W-1:0]            replace_limit,
  input  logic                                   queue_full,
  output logic                                   push,
  output logic [PATTERN_BYTES*sfr_pkg::BYTE_W-1:0] job_bytes,
  output sfr_pkg::job_ctrl_t                     job_ctrl
);
  import sfr_pkg::*;

  logic [BYTE_W-1:0]  held_r [PATTERN_BYTES];
  logic [BYTE_W-1:0]  held_nxt [PATTERN_BYTES];
  logic [HCNT_W-1:0]  held_cnt_r, held_cnt_nxt;
  logic [LIMIT_W-1:0] done_r, done_nxt;

  logic [BYTE_W-1:0]        win [PATTERN_BYTES];
  logic [CNT_W-1:0]         cnt, slen, start, seg_len, keep;
  logic [PATTERN_BYTES-1:0] fit;
  logic                     found, limit_hit, full;

  // effective pattern length
  always_comb begin
    if (search_length == '0) begin
      slen = CNT_W'(1);
    end else if (search_length > CNT_W'(PATTERN_BYTES)) begin
      slen = CNT_W'(PATTERN_BYTES);
    end else begin
      slen = search_length;
    end
  end

  // window: held bytes followed by the new byte
  assign cnt = {1'b0, held_cnt_r} + CNT_W'(1);

  always_comb begin
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      win[i] = (CNT_W'(i) < {1'b0, held_cnt_r}) ? held_r[i] : in_ch.data_byte;
    end
  end

  // every window suffix checked as a pattern prefix in parallel
  always_comb begin
    logic ok;
    for (int s = 0; s < PATTERN_BYTES; s++) begin
      ok = (CNT_W'(s) < cnt) && ((cnt - CNT_W'(s)) <= slen);
      for (int i = 0; i < PATTERN_BYTES; i++) begin
        if (i + s < PATTERN_BYTES) begin
          if ((CNT_W'(i + s) < cnt) &&
              (win[i + s] != search_pattern[i*BYTE_W +: BYTE_W])) begin
            ok = 1'b0;
          end
        end
      end
      fit[s] = ok;
    end
  end

  // leftmost suffix that can still match
  always_comb begin
    start = cnt;
    for (int s = PATTERN_BYTES - 1; s >= 0; s--) begin
      if (fit[s]) begin
        start = CNT_W'(s);
      end
    end
  end

  assign found     = |fit;
  assign seg_len   = cnt - start;
  assign limit_hit = (done_r >= replace_limit);
  assign full      = !limit_hit && found && (seg_len == slen);

  // job for the back end
  always_comb begin
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      job_bytes[i*BYTE_W +: BYTE_W] = win[i];
    end
    job_ctrl.n_bytes = (limit_hit || (in_ch.string_end && !full)) ? cnt : start;
    job_ctrl.rep     = full;
    job_ctrl.str_end = in_ch.string_end;
  end

  // bytes kept back for the next transaction
  assign keep = (!limit_hit && !full && !in_ch.string_end) ? seg_len : '0;

  always_comb begin
    for (int i = 0; i < PATTERN_BYTES; i++) begin
      held_nxt[i] = win[i];
      for (int s = 0; s < PATTERN_BYTES; s++) begin
        if (i + s < PATTERN_BYTES) begin
          if (start == CNT_W'(s)) begin
            held_nxt[i] = win[i + s];
          end
        end
      end
    end
    held_cnt_nxt = keep[HCNT_W-1:0];
    if (in_ch.string_end) begin
      done_nxt = '0;
    end else begin
      done_nxt = done_r + LIMIT_W'(full);
    end
  end

  // handshake
  assign in_ch.ready = !queue_full;
  assign push        = in_ch.valid && !queue_full;

  // held bytes
  always_ff @(posedge clk) begin
    if (push) begin
      held_r <= held_nxt;
    end
  end

  // match state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= '0;
      done_r     <= '0;
    end else if (push) begin
      held_cnt_r <= held_cnt_nxt;
      done_r     <= done_nxt;
    end
  end

endmodule

// File: rtl/sfr_fifo.sv
// sfr_fifo: two-entry job queue between the front and the back
`timescale 1ns / 1ps
module sfr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head_data,
  output logic             full,
  output logic             empty
);
  import sfr_pkg::*;

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r, count_nxt;
  logic             do_pop;

  assign full      = (count_r == QUEUE_FULL);
  assign empty     = (count_r == QUEUE_EMPTY);
  assign head_data = mem_r[rd_ptr_r];
  assign do_pop    = pop && !empty;

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= QUEUE_EMPTY;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// File: rtl/sfr_back.sv
// sfr_back: walks each job and drives one result per cycle into the output register while that register is free
`timescale 1ns / 1ps
module sfr_back #(
  parameter int PATTERN_BYTES = 8,
  parameter int REPLACE_BYTES = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     empty,
  input  logic [PATTERN_BYTES*sfr_pkg::BYTE_W-1:0] head_bytes,
  input  sfr_pkg::job_ctrl_t                       head_ctrl,
  output logic                                     pop,
  input  logic [sfr_pkg::CFG_DATA_W-1:0]           replace_text,
  input  logic [sfr_pkg::LEN_W-1:0]                replace_length,
  sfr_out_if.source                                out_ch
);
  import sfr_pkg::*;

  logic [CNT_W-1:0]  pos_r, pos_nxt, rpos, rlen;
  logic [TOT_W-1:0]  total;
  logic              slot_free, step, is_last;
  logic [BYTE_W-1:0] win_byte, rep_byte, sel_byte;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              byte_valid_r, byte_valid_nxt;
  logic              string_last_r, string_last_nxt;
  logic              run_last_r, run_last_nxt;

  // effective replacement length
  assign rlen = (replace_length > CNT_W'(REPLACE_BYTES)) ? CNT_W'(REPLACE_BYTES)
                                                         : replace_length;

  // results this job gives
  assign total   = {1'b0, head_ctrl.n_bytes} +
                   (head_ctrl.rep ? {1'b0, rlen} : TOT_W'(0));
  assign is_last = (({1'b0, pos_r} + TOT_W'(1)) == total);
  assign rpos    = pos_r - head_ctrl.n_bytes;

  // byte at the current position
  always_comb begin
    win_byte = '0;
    for (int k = 0; k < PATTERN_BYTES; k++) begin
      if (pos_r == CNT_W'(k)) begin
        win_byte = head_bytes[k*BYTE_W +: BYTE_W];
      end
    end
    rep_byte = '0;
    for (int k = 0; k < REPLACE_BYTES; k++) begin
      if (rpos == CNT_W'(k)) begin
        rep_byte = replace_text[k*BYTE_W +: BYTE_W];
      end
    end
    sel_byte = (pos_r < head_ctrl.n_bytes) ? win_byte : rep_byte;
  end

  assign slot_free = !out_valid_r || out_ch.ready;
  assign step      = !empty && slot_free;

  // sequencing and output register load
  always_comb begin
    pop             = 1'b0;
    pos_nxt         = pos_r;
    out_valid_nxt   = slot_free ? 1'b0 : out_valid_r;
    out_byte_nxt    = out_byte_r;
    byte_valid_nxt  = byte_valid_r;
    string_last_nxt = string_last_r;
    run_last_nxt    = run_last_r;
    if (step) begin
      if (total == '0) begin
        // nothing to emit: bare end marker or silent drop
        pop = 1'b1;
        if (head_ctrl.str_end) begin
          out_valid_nxt   = 1'b1;
          out_byte_nxt    = '0;
          byte_valid_nxt  = 1'b0;
          string_last_nxt = 1'b1;
          run_last_nxt    = 1'b1;
        end
      end else begin
        out_valid_nxt   = 1'b1;
        out_byte_nxt    = sel_byte;
        byte_valid_nxt  = 1'b1;
        string_last_nxt = head_ctrl.str_end && is_last;
        run_last_nxt    = is_last;
        if (is_last) begin
          pop     = 1'b1;
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + CNT_W'(1);
        end
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_byte_r    <= out_byte_nxt;
    byte_valid_r  <= byte_valid_nxt;
    string_last_r <= string_last_nxt;
    run_last_r    <= run_last_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.byte_valid  = byte_valid_r;
  assign out_ch.string_last = string_last_r;
  assign out_ch.run_last    = run_last_r;

endmodule

// File: rtl/sfr_checker.sv
// sfr_checker: port-level assertions for the find and replace block, bound to the top
`timescale 1ns / 1ps
module sfr_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sfr_pkg::BYTE_W-1:0] out_byte,
  input logic                       byte_valid,
  input logic                       string_last,
  input logic                       run_last
);

  // a stalled result stays offered
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // a bare end marker closes both the string and the transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> string_last && run_last)
    else $error("bare end marker not final");

  // a bare end marker carries a zero byte
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> out_byte == '0)
    else $error("bare end marker with nonzero byte");

  // the end of a string is also the end of its input transaction
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && string_last |-> run_last)
    else $error("string end without transaction end");

  // reset empties the output register
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

endmodule

bind stream_find_replace_top sfr_checker u_sfr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .byte_valid  (out_ch.byte_valid),
  .string_last (out_ch.string_last),
  .run_last    (out_ch.run_last)
);

// File: bench/stream_find_replace_top_tb.sv
// stream_find_replace_top_tb: self-checking testbench of the stream find and replace block
`timescale 1ns / 1ps
module stream_find_replace_top_tb;
  import sfr_pkg::*;

  localparam int PAT_BYTES    = 8;
  localparam int REP_BYTES    = 8;
  localparam int DRAIN_CYCLES = 8;
  localparam int QUIET_LIMIT  = 1000;
  localparam int PHASE_ITEMS  = 28;

  // one output transaction as the block should give it
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_last;
    logic       run_last;
  } text_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SEARCH_PATTERN;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  sfr_in_if  in_ch();
  sfr_out_if out_ch();

  stream_find_replace_top #(
    .PATTERN_BYTES(PAT_BYTES),
    .REPLACE_BYTES(REP_BYTES)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // predictor copy of the registers and the held window
  logic [63:0] m_pattern;
  logic [3:0]  m_slen;
  logic [63:0] m_repl;
  logic [3:0]  m_rlen;
  logic [31:0] m_limit;
  logic [31:0] m_done;
  logic [7:0]  m_held [0:PAT_BYTES-2];
  int          m_held_n;

  text_result_t text_due_q[$];
  int mismatches = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit idle_on = 1'b0;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void queue_char(input logic [7:0] ch);
    text_due_q.push_back({ch, 1'b1, 1'b0, 1'b0});
  endfunction

  // expected output transactions for one accepted input byte
  function automatic void find_replace_step(input logic [7:0] ch, input logic is_end);
    logic [7:0]   win [0:PAT_BYTES];
    text_result_t r;
    int cnt, pos, len, slen, rlen, base, i;
    bit fits;
    base = text_due_q.size();
    slen = (m_slen == 0) ? 1 : (m_slen > PAT_BYTES) ? PAT_BYTES : int'(m_slen);
    rlen = (m_rlen > REP_BYTES) ? REP_BYTES : int'(m_rlen);
    for (i = 0; i < m_held_n; i++) win[i] = m_held[i];
    win[m_held_n] = ch;
    cnt = m_held_n + 1;
    pos = 0;
    if (m_done >= m_limit) begin
      // limit reached: everything passes unchanged
      for (i = 0; i < cnt; i++) queue_char(win[i]);
      pos = cnt;
    end else begin
      while (pos < cnt) begin
        len = cnt - pos;
        fits = (len <= slen);
        for (i = 0; fits && i < len; i++)
          if (win[pos+i] != m_pattern[i*8 +: 8]) fits = 1'b0;
        if (fits) begin
          if (len == slen) begin
            for (i = 0; i < rlen; i++) queue_char(m_repl[i*8 +: 8]);
            m_done++;
            pos = cnt;
          end
          break;
        end
        queue_char(win[pos]);
        pos++;
      end
    end
    if (is_end) begin
      // flush the window, bare end marker when the string gave nothing
      for (i = pos; i < cnt; i++) queue_char(win[i]);
      if (text_due_q.size() == base) text_due_q.push_back('0);
      r = text_due_q.pop_back();
      r.string_last = 1'b1;
      text_due_q.push_back(r);
      m_held_n = 0;
      m_done = '0;
    end else begin
      m_held_n = 0;
      for (i = pos; i < cnt && m_held_n < PAT_BYTES - 1; i++) begin
        m_held[m_held_n] = win[i];
        m_held_n++;
      end
    end
    if (text_due_q.size() > base) begin
      r = text_due_q.pop_back();
      r.run_last = 1'b1;
      text_due_q.push_back(r);
    end
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    text_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (text_due_q.size() == 0) begin
        $error("out_byte: expected none, got %0h", out_ch.out_byte);
        mismatches++;
      end else begin
        want = text_due_q.pop_front();
        check_field("out_byte", want.out_byte, out_ch.out_byte);
        check_field("byte_valid", want.byte_valid, out_ch.byte_valid);
        check_field("string_last", want.string_last, out_ch.string_last);
        check_field("run_last", want.run_last, out_ch.run_last);
      end
    end
  end

  // result side backpressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) stall_left--;
    else if (idle_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 16);
    out_ch.ready <= rst_n && (stall_left == 0);
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("stream_find_replace_top_tb: done, errors");
      $finish;
    end
  end

  // one input transaction, with an optional gap ahead of it
  task automatic send_char(input logic [7:0] ch, input logic is_end);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= ch;
    in_ch.string_end <= is_end;
    do @(posedge clk); while (!in_ch.ready);
    find_replace_step(ch, is_end);
  endtask

  // stop sending, wait for every due result and let the pipeline empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (text_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_SEARCH_PATTERN: m_pattern = val;
      REG_SEARCH_LENGTH:  m_slen    = val[3:0];
      REG_REPLACE_TEXT:   m_repl    = val;
      REG_REPLACE_LENGTH: m_rlen    = val[3:0];
      REG_REPLACE_LIMIT:  m_limit   = val[31:0];
      default: ;
    endcase
  endtask

  // reset settings: a zero byte is the pattern and is deleted
  task automatic test_defaults();
    send_char(8'h00, 1'b1);
    send_char(8'h41, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hBE, 1'b1);
    settle();
  endtask

  // two byte pattern with a repeated first character and a flush at string end
  task automatic test_replace();
    cfg_write(REG_SEARCH_PATTERN, 64'h6261);
    cfg_write(REG_SEARCH_LENGTH, 64'd2);
    cfg_write(REG_REPLACE_TEXT, 64'h5A5958);
    cfg_write(REG_REPLACE_LENGTH, 64'd3);
    send_char(8'h78, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(8'h61, 1'b0);
    send_char(8'h62, 1'b1);
    send_char(8'h61, 1'b1);
    settle();
  endtask

  // oversized lengths clamp to eight, search length zero counts as one
  task automatic test_length_clamps();
    int i;
    cfg_write(REG_SEARCH_PATTERN, {64{1'b1}});
    cfg_write(REG_SEARCH_LENGTH, 64'd15);
    cfg_write(REG_REPLACE_TEXT, 64'h8877665544332211);
    cfg_write(REG_REPLACE_LENGTH, 64'd15);
    for (i = 0; i < PAT_BYTES; i++) send_char(8'hFF, i == PAT_BYTES - 1);
    settle();
    cfg_write(REG_SEARCH_LENGTH, 64'd0);
    send_char(8'h01, 1'b0);
    send_char(8'hFF, 1'b1);
    settle();
  endtask

  // limit of zero passes everything, limit of one replaces only the first match
  task automatic test_limit();
    cfg_write(REG_SEARCH_PATTERN, 64'h01);
    cfg_write(REG_SEARCH_LENGTH, 64'd1);
    cfg_write(REG_REPLACE_TEXT, {64{1'b1}});
    cfg_write(REG_REPLACE_LENGTH, 64'd1);
    cfg_write(REG_REPLACE_LIMIT, 64'd0);
    send_char(8'h01, 1'b1);
    settle();
    cfg_write(REG_REPLACE_LIMIT, 64'd1);
    send_char(8'h01, 1'b0);
    send_char(8'h01, 1'b1);
    settle();
  endtask

  // pattern changed while a partial match is held
  task automatic test_midstring_update();
    cfg_write(REG_REPLACE_LIMIT, 64'hFFFF_FFFF);
    cfg_write(REG_SEARCH_PATTERN, 64'h6261);
    cfg_write(REG_SEARCH_LENGTH, 64'd2);
    cfg_write(REG_REPLACE_TEXT, 64'h5A5A);
    cfg_write(REG_REPLACE_LENGTH, 64'd2);
    send_char(8'h61, 1'b0);
    settle();
    cfg_write(REG_SEARCH_PATTERN, 64'h6463);
    send_char(8'h63, 1'b0);
    send_char(8'h64, 1'b1);
    settle();
  endtask

  // random settings per phase, strings built mostly from pattern pieces
  task automatic test_random_text();
    logic [7:0]  txt[$];
    logic [7:0]  alpha [0:2];
    logic [63:0] pat;
    int ph, sent, slen, tlen, k, i;
    for (ph = 0; ph < 6; ph++) begin
      idle_on = (ph < 4);
      settle();
      for (i = 0; i < 3; i++) alpha[i] = 8'($urandom_range(1, 255));
      pat = '0;
      for (i = 0; i < PAT_BYTES; i++) pat[i*8 +: 8] = alpha[$urandom_range(0, 2)];
      slen = (ph == 0) ? PAT_BYTES : (ph == 1) ? 1 : $urandom_range(1, PAT_BYTES);
      cfg_write(REG_SEARCH_PATTERN, pat);
      cfg_write(REG_SEARCH_LENGTH, 64'(slen));
      cfg_write(REG_REPLACE_TEXT, {$urandom, $urandom});
      cfg_write(REG_REPLACE_LENGTH,
                (ph == 0) ? 64'(REP_BYTES) : 64'($urandom_range(0, REP_BYTES)));
      cfg_write(REG_REPLACE_LIMIT,
                ($urandom_range(0, 2) == 0) ? 64'($urandom_range(0, 3)) : 64'hFFFF_FFFF);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        txt.delete();
        tlen = $urandom_range(1, 12);
        while (txt.size() < tlen) begin
          case ($urandom_range(0, 4))
            0, 1: for (i = 0; i < slen; i++) txt.push_back(pat[i*8 +: 8]);
            2: begin
              // broken match: a prefix only
              k = $urandom_range(1, slen);
              for (i = 0; i < k; i++) txt.push_back(pat[i*8 +: 8]);
            end
            3: txt.push_back(alpha[$urandom_range(0, 2)]);
            default: txt.push_back(8'($urandom_range(1, 255)));
          endcase
        end
        for (i = 0; i < txt.size(); i++) send_char(txt[i], i == txt.size() - 1);
        sent += txt.size();
      end
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.string_end = 1'b0;
    out_ch.ready     = 1'b0;
    m_pattern = SEARCH_PATTERN_RST;
    m_slen    = SEARCH_LENGTH_RST;
    m_repl    = REPLACE_TEXT_RST;
    m_rlen    = REPLACE_LENGTH_RST;
    m_limit   = REPLACE_LIMIT_RST;
    m_done    = '0;
    m_held_n  = 0;
    foreach (m_held[i]) m_held[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;
    test_defaults();
    test_replace();
    test_length_clamps();
    test_limit();
    test_midstring_update();
    test_random_text();
    settle();
    if (mismatches == 0) begin
      $display("stream_find_replace_top_tb: done, clean");
    end else begin
      $display("stream_find_replace_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: stream_find_replace_top.f
rtl/sfr_pkg.sv
rtl/sfr_in_if.sv
rtl/sfr_out_if.sv
rtl/sfr_front.sv
rtl/sfr_fifo.sv
rtl/sfr_back.sv
rtl/stream_find_replace_top.sv
rtl/sfr_checker.sv
bench/stream_find_replace_top_tb.sv
